@@ design/assert_macros.svh @@
// Assertion macros shared by the hash engine RTL.
// Plain concurrent assertions on the rising clock edge, reset aware.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Property checked every clock, disabled while reset is low.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`endif

@@ design/sha_pkg.sv @@
// Shared constants, types and round functions for the SHA-256 engine.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned CountW     = 61;

    typedef logic [31:0] t_word;

    // Initial hash values.
    localparam t_word InitHash [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // Round constants.
    localparam t_word RoundK [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // Input action codes.
    localparam logic ActAbsorb = 1'b0;
    localparam logic ActFinish = 1'b1;

    // Compression control from sequencer to round unit.
    typedef struct packed {
        logic       start;  // load working vars from hash words
        logic       round;  // perform one round
        logic [5:0] rnd;    // round index
        logic       ffwd;   // feed-forward add into hash words
        logic       init;   // restore initial hash values
    } t_rnd_ctl;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

@@ design/sha256_hash_engine.sv @@
// SHA-256 hash engine top level: byte buffer, schedule, sequencer, output.
// Depends on sha_pkg, sha_round and assert_macros.svh.
//
// Usage: the s_axis channel takes one item per handshake; tuser = action
// (0 absorb, 1 finish), tdata = message byte. An absorb that fills the
// 64-byte block starts a compression of 64 rounds, one round per cycle in
// the shared round unit, plus load and feed-forward, during which
// s_axis_tready is low. A finish pads the message (one or two blocks,
// including the zero/length fill of one byte per cycle) and then presents
// eight digest words on m_axis, index 0 first, tlast on the eighth. Each
// word is held while m_axis_tready is low; no new input is taken until all
// eight are delivered. Absorbs are taken back to back while the engine is
// idle; input waits while the single round unit compresses a block.
// Synchronous active-low reset restores the initial hash values and a
// zero byte count.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha256_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_FFWD, S_PAD, S_OUT
    } t_state;

    t_state             r_state;
    logic [CountW-1:0]  r_count;
    t_word              r_buf [BlockBytes/4];   // bytes packed big-endian per word
    logic [5:0]         r_pos;
    logic [5:0]         r_rnd;
    logic               r_fin;     // finish in progress
    logic               r_final;   // block being compressed is the last
    logic [63:0]        r_bits;
    logic [2:0]         r_oidx;
    t_word              r_w [16];
    t_word              w_cur, w2, w15, hash_rd;
    t_rnd_ctl           ctl;
    logic               acc;
    logic [7:0]         pad_byte;

    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Schedule word for the current round.
    always_comb begin
        w2  = r_w[4'(r_rnd - 6'd2)];
        w15 = r_w[4'(r_rnd - 6'd15)];
        if (r_rnd < 6'd16) begin
            w_cur = r_buf[r_rnd[3:0]];
        end else begin
            w_cur = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10))
                  + r_w[4'(r_rnd - 6'd7)]
                  + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
                  + r_w[r_rnd[3:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ROUND) r_w[r_rnd[3:0]] <= w_cur;
    end

    // Padding byte: zeros, then length bytes big-endian at 56..63.
    always_comb begin
        pad_byte = 8'h00;
        if (r_final && r_pos >= 6'd56)
            pad_byte = 8'(r_bits >> (6'd56 - {r_pos[2:0], 3'd0}));
    end

    // Round unit control.
    always_comb begin
        ctl       = '0;
        ctl.start = (r_state == S_LOAD);
        ctl.round = (r_state == S_ROUND);
        ctl.rnd   = r_rnd;
        ctl.ffwd  = (r_state == S_FFWD);
        ctl.init  = (r_state == S_OUT) && m_axis_tready && (r_oidx == 3'd7);
    end

    sha_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_w      (w_cur),
        .i_rd_idx (r_oidx),
        .o_hash   (hash_rd)
    );

    // Block buffer writes: one byte lane per cycle, first byte in the top lane.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_buf[r_pos[5:2]][{~r_pos[1:0], 3'd0} +: 8] <=
                (s_axis_tuser == ActFinish) ? 8'h80 : s_axis_tdata;
        end else if (r_state == S_PAD) begin
            r_buf[r_pos[5:2]][{~r_pos[1:0], 3'd0} +: 8] <= pad_byte;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_final <= 1'b0;
            r_oidx  <= '0;
            r_bits  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_pos <= r_pos + 6'd1;
                        if (s_axis_tuser == ActAbsorb) begin
                            r_count <= r_count + 1'b1;
                            r_fin   <= 1'b0;
                            if (r_pos == 6'd63) r_state <= S_LOAD;
                        end else begin
                            r_bits  <= {r_count, 3'd0};
                            r_fin   <= 1'b1;
                            r_final <= (r_pos < 6'd56);
                            if (r_pos == 6'd63) r_state <= S_LOAD;
                            else r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_FFWD;
                end
                S_FFWD: begin
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_final) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_final <= 1'b1;
                        r_state <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_state <= S_IDLE;
                            r_count <= '0;
                            r_pos   <= '0;
                            r_fin   <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output: hash words held stable in the round unit while stalled.
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_oidx, hash_rd};
    assign m_axis_tlast  = (r_oidx == 3'd7);

    `ASSERT_IMPL(a_no_in_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `ASSERT_IMPL(a_out_final, i_clk, i_rst_n, m_axis_tvalid, r_fin && r_final)
    `ASSERT_IMPL(a_rnd_wrap, i_clk, i_rst_n, (r_state == S_ROUND) && (r_rnd == 6'd63), ##1 (r_state == S_FFWD))
    `ASSERT_IMPL(a_last_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, ##1 (r_count == '0 && r_pos == '0))
endmodule

@@ design/sha_round.sv @@
// One SHA-256 round per cycle while i_ctl.round is set, plus hash-word state and feed-forward.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_rnd_ctl  i_ctl,
    input  sha_pkg::t_word     i_w,
    input  logic [2:0]         i_rd_idx,
    output sha_pkg::t_word     o_hash
);
    import sha_pkg::*;

    t_word r_h [8];
    t_word r_v [8];
    t_word s1, ch, s0, mj, t1, t2;

    // Round arithmetic on the working variables.
    always_comb begin
        s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + s1 + ch + RoundK[i_ctl.rnd] + i_w;
        t2 = s0 + mj;
    end

    // Hash words: initial values on reset or init, feed-forward add on ffwd.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int j = 0; j < 8; j++) r_h[j] <= InitHash[j];
        end else if (i_ctl.ffwd) begin
            for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
        end
    end

    // Working variables: payload, no reset.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
        end else if (i_ctl.round) begin
            for (int j = 1; j < 8; j++) r_v[j] <= r_v[j-1];
            r_v[4] <= r_v[3] + t1;
            r_v[0] <= t1 + t2;
        end
    end

    assign o_hash = r_h[i_rd_idx];
endmodule
